### design/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the page tag directory: sizes, opcodes,
// the stored tag layout and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ID_W    = 32;
    localparam int FORK_W  = 2;
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 7;

    localparam logic [ID_W-1:0] BLOCK_MAX = {ID_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_WRITE  = 3'd1,
        OP_READ   = 3'd2,
        OP_EXISTS = 3'd3,
        OP_COUNT  = 3'd4
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]   tablespace;
        logic [ID_W-1:0]   database;
        logic [ID_W-1:0]   relation;
        logic [FORK_W-1:0] fork_num;
        logic [ID_W-1:0]   block;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### design/page_tag_directory.sv
// Clear and undefined opcodes go straight to the result; other operations
// scan the used slots one per cycle through the tag RAM read port; a write,
// lookup or exists query stops at its first match. A finished result waits
// until the previous result has been taken through out_ready.
// Throughput: one item at a time; the next item is taken once the controller
// is idle again. Reset empties the directory (used count 0); tag RAM contents
// are not cleared, since slots at or above the used count are never read.
// ----------------------------------------------------------------------------
// page_tag_directory
// Fully associative directory of page tags held in one tag RAM, searched by
// a sequential scan; new tags are appended at the used count.
// ----------------------------------------------------------------------------
`default_nettype none

module page_tag_directory (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [ptd_pkg::OP_W-1:0]   opcode,
    input  wire logic [ptd_pkg::ID_W-1:0]   tablespace_id,
    input  wire logic [ptd_pkg::ID_W-1:0]   database_id,
    input  wire logic [ptd_pkg::ID_W-1:0]   relation_id,
    input  wire logic [ptd_pkg::FORK_W-1:0] fork_req,
    input  wire logic [ptd_pkg::ID_W-1:0]   block_number,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            hit,
    output logic [ptd_pkg::SLOT_W-1:0]      slot,
    output logic                            overflow,
    output logic                            allocated,
    output logic [ptd_pkg::ID_W-1:0]        block_count
);

    import ptd_pkg::*;

    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    entry_t             key_reg, key_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   where_reg, where_next;
    logic [ID_W-1:0]    max_reg, max_next;

    logic               out_valid_reg, out_valid_next;
    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               overflow_reg, overflow_next;
    logic               allocated_reg, allocated_next;
    logic [ID_W-1:0]    count_reg, count_next;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    entry_t             ram_rdata;

    logic               fork_match, tag_match, full;

    ptd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign fork_match = (ram_rdata.tablespace == key_reg.tablespace)
                     && (ram_rdata.database == key_reg.database)
                     && (ram_rdata.relation == key_reg.relation)
                     && (ram_rdata.fork_num == key_reg.fork_num);
    assign tag_match  = fork_match && (ram_rdata.block == key_reg.block);
    assign full       = (used_reg == CNT_W'(ENTRIES));
    assign ram_waddr  = used_reg[IDX_W-1:0];
    assign ram_raddr  = idx_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        where_reg     <= where_next;
        max_reg       <= max_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
        overflow_reg  <= overflow_next;
        allocated_reg <= allocated_next;
        count_reg     <= count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        where_next     = where_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        overflow_next  = overflow_reg;
        allocated_next = allocated_reg;
        count_next     = count_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next             = opcode;
                    key_next.tablespace = tablespace_id;
                    key_next.database   = database_id;
                    key_next.relation   = relation_id;
                    key_next.fork_num   = fork_req;
                    key_next.block      = block_number;
                    idx_next            = '0;
                    pend_next           = 1'b0;
                    found_next          = 1'b0;
                    where_next          = '0;
                    max_next            = '0;
                    unique case (opcode) inside
                        OP_CLEAR:
                        begin
                            used_next  = '0;
                            state_next = ST_DONE;
                        end
                        OP_WRITE, OP_READ, OP_EXISTS, OP_COUNT:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // check the entry read last cycle
                if (pend_reg && fork_match)
                begin
                    if (op_reg == OP_COUNT)
                    begin
                        found_next = 1'b1;
                        if (!found_reg || (ram_rdata.block > max_reg))
                        begin
                            max_next = ram_rdata.block;
                        end
                    end
                    else if (op_reg == OP_EXISTS || tag_match)
                    begin
                        found_next = 1'b1;
                        where_next = cmp_idx_reg;
                    end
                end

                if (found_next && op_reg != OP_COUNT)
                begin
                    // first match ends the search
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else if (idx_reg < used_reg)
                begin
                    ram_re       = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg[IDX_W-1:0];
                    idx_next     = CNT_W'(idx_reg + 1'b1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    slot_next      = '0;
                    overflow_next  = 1'b0;
                    allocated_next = 1'b0;
                    count_next     = '0;
                    case (op_reg)
                        OP_WRITE:
                        begin
                            if (found_reg)
                            begin
                                slot_next = SLOT_W'(where_reg);
                            end
                            else if (full)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                // append at the next free slot
                                ram_we         = 1'b1;
                                slot_next      = SLOT_W'(used_reg);
                                allocated_next = 1'b1;
                                used_next      = CNT_W'(used_reg + 1'b1);
                            end
                        end
                        OP_READ:
                        begin
                            hit_next = found_reg;
                            if (found_reg)
                            begin
                                slot_next = SLOT_W'(where_reg);
                            end
                        end
                        OP_EXISTS:
                        begin
                            hit_next = found_reg;
                        end
                        OP_COUNT:
                        begin
                            if (found_reg)
                            begin
                                count_next = (max_reg == BLOCK_MAX) ? BLOCK_MAX
                                           : ID_W'(max_reg + 1'b1);
                            end
                        end
                        default:
                        begin
                            hit_next = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign slot        = slot_reg;
    assign overflow    = overflow_reg;
    assign allocated   = allocated_reg;
    assign block_count = count_reg;

endmodule

`default_nettype wire

### design/ptd_ram.sv
// ----------------------------------------------------------------------------
// ptd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
